// ===== rtl/tms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// TDMA membership package
// Shared widths, state codes, register indices, controller commands and status records.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int NumAgents = 5;
    localparam int AgentW    = 3;
    localparam int SlotW     = 3;
    localparam int CntW      = 3;
    localparam int PeriodW   = 17;
    localparam int DelayW    = 16;
    localparam int ElapsedW  = 24;
    localparam int SilentW   = 4;
    localparam int VecW      = 10;
    localparam int DivW      = 20;
    localparam int MaxVal    = 131071;

    localparam logic [1:0] ST_OFF = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;
    localparam logic [1:0] ST_INS = 2'd2;
    localparam logic [1:0] ST_REM = 2'd3;

    localparam logic [2:0] REG_SELF   = 3'd0;
    localparam logic [2:0] REG_PERIOD = 3'd1;
    localparam logic [2:0] REG_LINK   = 3'd2;
    localparam logic [2:0] REG_MINUPD = 3'd3;
    localparam logic [2:0] REG_REMOVE = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the input transaction
        logic tick_walk;  // advance states and renumber (tick)
        logic rx_prep;    // heard flag, early check, dividend setup
        logic div_start;  // load the serial divider
        logic div_step;   // one quotient bit
        logic rx_finish;  // apply expected offset
        logic emit;       // load the output register
    } tms_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic div_last;
    } tms_stat_t;

endpackage : tms_pkg
`default_nettype wire

// ===== rtl/tms_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// TDMA membership controller
// Sequences a tick or a receive through the datapath and the output handshake.
// ----------------------------------------------------------------------------
module tms_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic              out_free,
    input  wire tms_pkg::tms_stat_t stat,
    output logic                   in_ready,
    output tms_pkg::tms_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_DIVLOAD, S_DIV, S_FINISH, S_EMIT
    } state_t;

    state_t state_reg;

    // Commands decode from the state, the input handshake and the datapath status.
    always_comb
    begin
        cmd           = '0;
        cmd.latch     = in_fire;
        cmd.tick_walk = (state_reg == S_DECODE) && stat.is_tick;
        cmd.rx_prep   = (state_reg == S_DECODE) && !stat.is_tick;
        cmd.div_start = (state_reg == S_DIVLOAD);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.rx_finish = (state_reg == S_FINISH);
        cmd.emit      = (state_reg == S_EMIT) && out_free;
        in_ready      = (state_reg == S_IDLE);
    end

    // A receive loads its divider during decode and goes straight to division.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:    if (in_fire) state_reg <= S_DECODE;
                S_DECODE:  state_reg <= stat.is_tick ? S_DIVLOAD : S_DIV;
                S_DIVLOAD: state_reg <= S_DIV;
                S_DIV:     if (stat.div_last) state_reg <= S_FINISH;
                S_FINISH:  state_reg <= S_EMIT;
                S_EMIT:    if (out_free) state_reg <= S_IDLE;
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

endmodule : tms_ctrl
`default_nettype wire

// ===== rtl/tms_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// TDMA membership datapath
// Agent table, phase arithmetic, serial divider and result register.
// ----------------------------------------------------------------------------
module tms_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tms_pkg::tms_cmd_t             cmd,
    output tms_pkg::tms_stat_t                 stat,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [tms_pkg::PeriodW-1:0]   cfg_data,
    input  wire logic                          in_op,
    input  wire logic [tms_pkg::AgentW-1:0]    in_agent,
    input  wire logic [tms_pkg::ElapsedW-1:0]  in_elapsed,
    output logic [tms_pkg::PeriodW-1:0]        res_tracked,
    output logic                               res_status,
    output logic                               res_lv,
    output logic [tms_pkg::PeriodW-1:0]        res_lu,
    output logic [tms_pkg::SlotW-1:0]          res_slot,
    output logic [tms_pkg::CntW-1:0]           res_active,
    output logic [tms_pkg::VecW-1:0]           res_vec,
    output logic [31:0]                        res_round
);
    localparam int N = tms_pkg::NumAgents;
    localparam int DW = tms_pkg::DivW;

    // Configuration registers.
    logic [2:0]                   self_reg;
    logic [tms_pkg::PeriodW-1:0]  period_reg;
    logic [tms_pkg::DelayW-1:0]   link_reg, minupd_reg;
    logic [tms_pkg::SilentW-1:0]  remrnd_reg;

    // Agent table and global state.
    logic [1:0]                   mstate_reg [N];
    logic [N-1:0]                 heard_reg;
    logic [tms_pkg::SilentW-1:0]  silent_reg [N];
    logic [tms_pkg::SlotW-1:0]    slot_reg [N];
    logic [tms_pkg::PeriodW-1:0]  track_reg, limit_reg;
    logic [tms_pkg::CntW-1:0]     active_reg;
    logic [31:0]                  round_reg;

    // Transaction and work registers.
    logic                          op_reg;
    logic [tms_pkg::AgentW-1:0]    agent_reg;
    logic [tms_pkg::ElapsedW-1:0]  elapsed_reg;
    logic                          early_reg, rxv_reg, neg_reg;
    logic [DW-1:0]                 rem_reg, quo_reg, dvd_reg;
    logic [tms_pkg::CntW+1:0]      dvs_reg;
    logic [4:0]                    bit_reg;
    logic                          lv_reg;
    logic [tms_pkg::PeriodW-1:0]   lu_reg;

    logic self_ok, agent_ok;
    logic [tms_pkg::SlotW-1:0] own_slot, rx_slot;
    assign self_ok  = (self_reg < 3'(N));
    assign agent_ok = (agent_reg < 3'(N));
    assign own_slot = self_ok ? slot_reg[self_reg] : '0;
    assign rx_slot  = agent_ok ? slot_reg[agent_reg] : '0;

    // Tick: next member states in parallel, then renumber as a prefix count.
    logic [1:0]                  ns [N];
    logic [tms_pkg::SilentW-1:0] nsil [N];
    logic [tms_pkg::CntW-1:0]    nslot [N];
    logic [tms_pkg::CntW-1:0]    ncount;
    logic [tms_pkg::SilentW-1:0] sil_inc;
    always_comb
    begin
        ncount = '0;
        for (int i = 0; i < N; i++)
        begin
            sil_inc = silent_reg[i] + 4'd1;
            ns[i]   = mstate_reg[i];
            nsil[i] = silent_reg[i];
            if (self_ok && self_reg == 3'(i))
                ns[i] = tms_pkg::ST_RUN;
            else
            begin
                unique case (mstate_reg[i])
                    tms_pkg::ST_RUN: if (!heard_reg[i]) ns[i] = tms_pkg::ST_REM;
                    tms_pkg::ST_OFF: if (heard_reg[i]) ns[i] = tms_pkg::ST_INS;
                    tms_pkg::ST_INS:
                        ns[i] = heard_reg[i] ? tms_pkg::ST_RUN : tms_pkg::ST_OFF;
                    default:
                    begin
                        if (heard_reg[i])
                        begin
                            nsil[i] = '0;
                            ns[i]   = tms_pkg::ST_RUN;
                        end
                        else if (sil_inc >= remrnd_reg)
                        begin
                            nsil[i] = '0;
                            ns[i]   = tms_pkg::ST_OFF;
                        end
                        else
                            nsil[i] = sil_inc;
                    end
                endcase
            end
            nslot[i] = ncount;
            if (ns[i] == tms_pkg::ST_RUN || ns[i] == tms_pkg::ST_REM)
                ncount = ncount + 3'd1;
        end
    end

    // Receive: signed slot difference times period, magnitude for the divider.
    logic signed [4:0]             sdiff;
    logic [tms_pkg::SlotW-1:0]     sdiff_mag;
    logic [DW-1:0]                 prod;
    logic signed [25:0]            real_diff;
    assign sdiff     = $signed({2'b00, rx_slot}) - $signed({2'b00, own_slot});
    assign sdiff_mag = sdiff[4] ? 3'(-sdiff) : 3'(sdiff);
    assign prod      = {{(DW-tms_pkg::SlotW){1'b0}}, sdiff_mag}
                     * {{(DW-tms_pkg::PeriodW){1'b0}}, period_reg};
    assign real_diff = $signed({2'b00, elapsed_reg}) - $signed({10'd0, link_reg});

    // Tick divisor is 3*active for 2*period; receive uses active.
    logic [tms_pkg::CntW-1:0] act_div;
    assign act_div = (active_reg == '0) ? 3'd1 : active_reg;

    // Restoring divider, one quotient bit a cycle.
    logic [DW:0] trial;
    assign trial = {rem_reg, dvd_reg[DW-1]} - {{(DW-4){1'b0}}, dvs_reg};

    // Receive finish. A negative offset that truncates to zero stays zero;
    // any other negative offset gets one period added.
    logic signed [DW+1:0] expected, load;
    logic signed [26:0]   delta;
    always_comb
    begin
        expected = (neg_reg && (quo_reg != '0))
                 ? ($signed({5'd0, period_reg}) - $signed({2'b00, quo_reg}))
                 : $signed({2'b00, quo_reg});
        delta = $signed({real_diff[25], real_diff})
              - $signed({{5{expected[DW+1]}}, expected});
        load  = $signed({5'd0, period_reg}) - expected - $signed({6'd0, link_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_reg   <= 3'd3;
            period_reg <= 17'd75000;
            link_reg   <= 16'd4000;
            minupd_reg <= 16'd1000;
            remrnd_reg <= 4'd10;
            for (int i = 0; i < N; i++)
            begin
                mstate_reg[i] <= tms_pkg::ST_OFF;
                silent_reg[i] <= '0;
                slot_reg[i]   <= '0;
            end
            heard_reg  <= '0;
            track_reg  <= '0;
            limit_reg  <= '0;
            active_reg <= 3'd1;
            round_reg  <= '0;
            op_reg <= 1'b0;
            early_reg <= 1'b0;
            rxv_reg <= 1'b0;
            lv_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tms_pkg::REG_SELF:   self_reg   <= cfg_data[2:0];
                    tms_pkg::REG_PERIOD: period_reg <= cfg_data;
                    tms_pkg::REG_LINK:   link_reg   <= cfg_data[15:0];
                    tms_pkg::REG_MINUPD: minupd_reg <= cfg_data[15:0];
                    tms_pkg::REG_REMOVE: remrnd_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (cmd.latch)
            begin
                op_reg      <= in_op;
                agent_reg   <= in_agent;
                elapsed_reg <= in_elapsed;
                lv_reg      <= 1'b0;
                lu_reg      <= '0;
                early_reg   <= 1'b0;
                rxv_reg     <= 1'b0;
            end
            if (cmd.tick_walk)
            begin
                for (int i = 0; i < N; i++)
                begin
                    mstate_reg[i] <= ns[i];
                    silent_reg[i] <= nsil[i];
                    if (ns[i] == tms_pkg::ST_RUN || ns[i] == tms_pkg::ST_REM)
                        slot_reg[i] <= nslot[i];
                end
                heard_reg  <= '0;
                active_reg <= ncount;
                round_reg  <= round_reg + 32'd1;
            end
            if (cmd.rx_prep)
            begin
                if (agent_ok)
                begin
                    heard_reg[agent_reg] <= 1'b1;
                    early_reg <= real_diff[25];
                    rxv_reg   <= !real_diff[25];
                end
                // Divide the offset magnitude by the active count.
                neg_reg   <= sdiff[4];
                dvd_reg   <= prod;
                dvs_reg   <= {2'b00, act_div};
                rem_reg   <= '0;
                bit_reg   <= 5'(DW - 1);
            end
            if (cmd.div_start)
            begin
                neg_reg <= 1'b0;
                dvd_reg <= DW'({period_reg, 1'b0});
                dvs_reg <= 5'(3 * ((active_reg == '0) ? 3'd1 : active_reg));
                rem_reg <= '0;
                bit_reg <= 5'(DW - 1);
            end
            if (cmd.div_step)
            begin
                if (!trial[DW])
                    rem_reg <= trial[DW-1:0];
                else
                    rem_reg <= {rem_reg[DW-2:0], dvd_reg[DW-1]};
                quo_reg <= {quo_reg[DW-2:0], !trial[DW]};
                dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                bit_reg <= bit_reg - 5'd1;
            end
            if (cmd.rx_finish)
            begin
                if (op_reg)
                    limit_reg <= quo_reg[tms_pkg::PeriodW-1:0];
                else if (rxv_reg)
                begin
                    if (own_slot == '0)
                    begin
                        if (delta > $signed({10'd0, track_reg}) &&
                            delta < $signed({10'd0, limit_reg}) &&
                            delta > $signed({11'd0, minupd_reg}))
                            track_reg <= delta[tms_pkg::PeriodW-1:0];
                    end
                    else if (rx_slot == '0)
                    begin
                        lv_reg <= 1'b1;
                        if (load < 0)
                            lu_reg <= '0;
                        else if (load > tms_pkg::MaxVal)
                            lu_reg <= 17'(tms_pkg::MaxVal);
                        else
                            lu_reg <= load[tms_pkg::PeriodW-1:0];
                    end
                end
            end
        end
    end

    // Ticks and receives both end their division when the bit count runs out.
    assign stat.is_tick  = op_reg;
    assign stat.div_last = (bit_reg == '0);

    // Result register.
    localparam int VecW_L = tms_pkg::VecW;
    logic [VecW_L-1:0] vec;
    always_comb
    begin
        vec = '0;
        for (int i = 0; i < N && i < 5; i++)
            vec[2*i +: 2] = mstate_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_status  <= early_reg;
            res_tracked <= track_reg;
            res_lv      <= lv_reg;
            res_lu      <= lu_reg;
            res_slot    <= own_slot;
            res_active  <= active_reg;
            res_vec     <= vec;
            res_round   <= round_reg;
        end
    end

endmodule : tms_dp
`default_nettype wire

// ===== rtl/tdma_membership_slot_sync.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// TDMA membership and slot-phase controller
// Round ticks update the agent table; receptions measure phase error.
// ----------------------------------------------------------------------------
// A tick's result is loaded after a decode state, a state that loads the
// divider, the serial division of the 20-bit dividend for the delta limit, a
// finish state and an output state. A reception loads its divider while
// decoding and skips the load state; its division forms the expected slot
// offset. The input is ready again the cycle after a result is loaded. One
// transaction is in flight at a time; a finished result sits in the output
// register until taken, and the next result waits in its output state while
// it is held.
module tdma_membership_slot_sync (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // agent_index[2:0], elapsed_us[26:3]
    input  wire logic        s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // tracked_delay_us, timer_load_us,
                                             // own_slot, active_count,
                                             // state_vector, round_count
    output logic [1:0]       m_axis_tuser,   // status, timer_load_valid
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    tms_pkg::tms_cmd_t  cmd;
    tms_pkg::tms_stat_t stat;
    logic in_ready, in_fire, out_free, ovalid_reg;
    logic [16:0] tr, lu;
    logic st, lv;
    logic [2:0] sl, ac;
    logic [9:0] vc;
    logic [31:0] rc;

    assign in_fire  = s_axis_tvalid && in_ready;
    assign out_free = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = in_ready;

    tms_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .stat(stat), .in_ready(in_ready), .cmd(cmd)
    );

    tms_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_op(s_axis_tuser), .in_agent(s_axis_tdata[2:0]),
        .in_elapsed(s_axis_tdata[26:3]),
        .res_tracked(tr), .res_status(st), .res_lv(lv), .res_lu(lu),
        .res_slot(sl), .res_active(ac), .res_vec(vc), .res_round(rc)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.emit)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, rc, vc, ac, sl, lu, tr};
    assign m_axis_tuser  = {lv, st};

endmodule : tdma_membership_slot_sync
`default_nettype wire

// ===== rtl/tms_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// TDMA membership port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module tms_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [87:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    // A held result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Input is not taken while the previous one is in work.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction accepted during work");

    // A reload never comes with an early reception.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("reload on early reception");

    // Active count stays within the agent range.
    a_act: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:37] <= 3'd5)
        else $error("active count out of range");
endmodule : tms_checker

bind tdma_membership_slot_sync tms_checker u_tms_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

// ===== sim/tdma_membership_slot_sync_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TDMA membership checker
// Watches both stream channels and the register port, keeps its own copy of
// the agent table and registers, and compares every result transaction with
// the predicted one, field by field.
// ----------------------------------------------------------------------------
module tdma_membership_slot_sync_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [87:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    output int               fail_count,
    output int               pending_count,
    output int               result_count
);

    typedef struct packed {
        logic        status;
        logic        load_valid;
        logic [16:0] tracked;
        logic [16:0] load_us;
        logic [2:0]  own_slot;
        logic [2:0]  active;
        logic [9:0]  states;
        logic [31:0] rounds;
    } sync_result_t;

    // Shadow registers.
    logic [2:0]  self_idx;
    logic [16:0] period;
    logic [15:0] link_delay;
    logic [15:0] min_update;
    logic [3:0]  remove_limit;

    // Shadow agent table.
    logic [1:0]  member [tms_pkg::NumAgents];
    logic        heard [tms_pkg::NumAgents];
    logic [3:0]  silent [tms_pkg::NumAgents];
    logic [2:0]  slot [tms_pkg::NumAgents];
    logic [16:0] track_delay;
    logic [16:0] limit_delta;
    logic [2:0]  active_total;
    logic [31:0] round_ctr;

    sync_result_t expected_results[$];

    function automatic logic [2:0] own_slot_now();
        return (self_idx < tms_pkg::NumAgents) ? slot[self_idx] : 3'd0;
    endfunction

    function automatic longint active_div();
        return (active_total == 0) ? 1 : longint'(active_total);
    endfunction

    task automatic advance_round();
        int cnt;
        cnt = 0;
        for (int i = 0; i < tms_pkg::NumAgents; i++)
        begin
            if (i != self_idx)
            begin
                case (member[i])
                    tms_pkg::ST_RUN: if (!heard[i]) member[i] = tms_pkg::ST_REM;
                    tms_pkg::ST_OFF: if (heard[i]) member[i] = tms_pkg::ST_INS;
                    tms_pkg::ST_INS:
                        member[i] = heard[i] ? tms_pkg::ST_RUN : tms_pkg::ST_OFF;
                    default:
                    begin
                        if (heard[i])
                        begin
                            silent[i] = 0;
                            member[i] = tms_pkg::ST_RUN;
                        end
                        else
                        begin
                            silent[i] = silent[i] + 4'd1;
                            if (silent[i] >= remove_limit)
                            begin
                                member[i] = tms_pkg::ST_OFF;
                                silent[i] = 0;
                            end
                        end
                    end
                endcase
            end
        end
        if (self_idx < tms_pkg::NumAgents) member[self_idx] = tms_pkg::ST_RUN;
        for (int i = 0; i < tms_pkg::NumAgents; i++)
        begin
            if (member[i] == tms_pkg::ST_RUN || member[i] == tms_pkg::ST_REM)
            begin
                slot[i] = cnt[2:0];
                cnt++;
            end
            heard[i] = 0;
        end
        active_total = cnt[2:0];
        limit_delta = 17'((longint'(period) * 2) / (3 * active_div()));
        round_ctr = round_ctr + 1;
    endtask

    // Phase error of a received frame; fills status and reload fields.
    task automatic measure_phase(input int a, input logic [23:0] elapsed,
                                 inout sync_result_t r);
        longint real_diff, offset, delta, load;
        longint own;
        own = own_slot_now();
        heard[a] = 1;
        real_diff = longint'(elapsed) - longint'(link_delay);
        if (real_diff < 0)
        begin
            r.status = 1;
            return;
        end
        offset = (longint'(slot[a]) - own) * longint'(period) / active_div();
        if (offset < 0) offset += period;
        delta = real_diff - offset;
        if (own == 0)
        begin
            if (delta > longint'(track_delay) && delta < longint'(limit_delta) &&
                delta > longint'(min_update))
                track_delay = delta[16:0];
        end
        else if (slot[a] == 0)
        begin
            load = longint'(period) - offset - longint'(link_delay);
            if (load < 0) load = 0;
            if (load > tms_pkg::MaxVal) load = tms_pkg::MaxVal;
            r.load_valid = 1;
            r.load_us = load[16:0];
        end
    endtask

    function automatic sync_result_t unpack_result();
        sync_result_t r;
        r.status     = m_axis_tuser[0];
        r.load_valid = m_axis_tuser[1];
        r.tracked    = m_axis_tdata[16:0];
        r.load_us    = m_axis_tdata[33:17];
        r.own_slot   = m_axis_tdata[36:34];
        r.active     = m_axis_tdata[39:37];
        r.states     = m_axis_tdata[49:40];
        r.rounds     = m_axis_tdata[81:50];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sync_result_t r, got, want;
        int a;
        if (!rst_n)
        begin
            self_idx = 3; period = 75000; link_delay = 4000;
            min_update = 1000; remove_limit = 10;
            for (int i = 0; i < tms_pkg::NumAgents; i++)
            begin
                member[i] = tms_pkg::ST_OFF; heard[i] = 0; silent[i] = 0; slot[i] = 0;
            end
            track_delay = 0; limit_delta = 0; active_total = 1; round_ctr = 0;
            expected_results.delete();
            fail_count = 0;
            pending_count = 0;
            result_count = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    tms_pkg::REG_SELF:   self_idx = cfg_data[2:0];
                    tms_pkg::REG_PERIOD: period = cfg_data;
                    tms_pkg::REG_LINK:   link_delay = cfg_data[15:0];
                    tms_pkg::REG_MINUPD: min_update = cfg_data[15:0];
                    tms_pkg::REG_REMOVE: remove_limit = cfg_data[3:0];
                    default: ;
                endcase
            end
            // Input transaction: predict its result.
            if (s_axis_tvalid && s_axis_tready)
            begin
                r = '0;
                a = int'(s_axis_tdata[2:0]);
                if (s_axis_tuser) advance_round();
                else if (a < tms_pkg::NumAgents) measure_phase(a, s_axis_tdata[26:3], r);
                r.tracked  = track_delay;
                r.own_slot = own_slot_now();
                r.active   = active_total;
                for (int i = 0; i < tms_pkg::NumAgents; i++) r.states[2*i +: 2] = member[i];
                r.rounds   = round_ctr;
                expected_results.push_back(r);
            end
            // Output transaction: compare with the oldest prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = unpack_result();
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.load_valid !== want.load_valid)
                    begin
                        $error("timer_load_valid: expected %0d, got %0d",
                               want.load_valid, got.load_valid);
                        fail_count++;
                    end
                    if (got.tracked !== want.tracked)
                    begin
                        $error("tracked_delay_us: expected %0d, got %0d",
                               want.tracked, got.tracked);
                        fail_count++;
                    end
                    if (got.load_us !== want.load_us)
                    begin
                        $error("timer_load_us: expected %0d, got %0d",
                               want.load_us, got.load_us);
                        fail_count++;
                    end
                    if (got.own_slot !== want.own_slot)
                    begin
                        $error("own_slot: expected %0d, got %0d",
                               want.own_slot, got.own_slot);
                        fail_count++;
                    end
                    if (got.active !== want.active)
                    begin
                        $error("active_count: expected %0d, got %0d",
                               want.active, got.active);
                        fail_count++;
                    end
                    if (got.states !== want.states)
                    begin
                        $error("state_vector: expected %h, got %h",
                               want.states, got.states);
                        fail_count++;
                    end
                    if (got.rounds !== want.rounds)
                    begin
                        $error("round_count: expected %0d, got %0d",
                               want.rounds, got.rounds);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== sim/tdma_membership_slot_sync_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TDMA membership testbench
// Drives ticks and receptions through several register settings, with random
// gaps on both streams; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tdma_membership_slot_sync_tb;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_TICK = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          tick_total;
    int          rx_total;
    int          stall_left;
    bit          stall_enable;

    tdma_membership_slot_sync DUT (.*);

    tdma_membership_slot_sync_checker u_checker (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    // Receiver stalls: random gaps, mostly short and a few long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else if (!stall_enable)
            m_axis_tready <= 1'b1;
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = gap_length();
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Valid stays high into a back-to-back transaction; drain drops it.
    task automatic send_event(input logic op, input logic [2:0] agent,
                              input logic [23:0] elapsed);
        int gap;
        gap = stall_enable ? gap_length() : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, elapsed, agent};
        do @(posedge clk); while (!s_axis_tready);
        if (op == OP_TICK) tick_total++;
        else rx_total++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random traffic: each round a tick, then up to five receptions, mostly from valid agents, at random elapsed times.
    task automatic run_rounds(input int n_rounds);
        logic [2:0]  agent;
        logic [23:0] elapsed;
        for (int r = 0; r < n_rounds; r++)
        begin
            send_event(OP_TICK, 3'($urandom), 24'($urandom));
            for (int k = 0; k < $urandom_range(0, 5); k++)
            begin
                agent = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
                case ($urandom_range(0, 3))
                    0: elapsed = 24'($urandom);
                    1: elapsed = 24'($urandom_range(0, 8000));
                    default: elapsed = 24'($urandom_range(0, 140000));
                endcase
                send_event(OP_RX, agent, elapsed);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we = 1'b0;
        cfg_index = tms_pkg::REG_SELF;
        cfg_data = '0;
        stall_enable = 1'b0;
        tick_total = 0;
        rx_total = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (30) @(posedge clk);

        // Directed: reset settings, field extremes, early and stray agents.
        send_event(OP_RX, 3'd0, 24'd5000);
        send_event(OP_TICK, 3'd7, 24'hFFFFFF);
        send_event(OP_RX, 3'd0, 24'd0);
        send_event(OP_RX, 3'd1, 24'hFFFFFF);
        send_event(OP_RX, 3'd7, 24'd20000);
        send_event(OP_RX, 3'd5, 24'd20000);
        send_event(OP_TICK, 3'd0, 24'd0);
        send_event(OP_RX, 3'd0, 24'd3999);
        send_event(OP_RX, 3'd1, 24'd4000);
        send_event(OP_TICK, 3'd0, 24'd0);
        send_event(OP_RX, 3'd0, 24'd30000);
        send_event(OP_RX, 3'd4, 24'd60000);
        send_event(OP_TICK, 3'd0, 24'd0);
        send_event(OP_TICK, 3'd0, 24'd0);
        drain();

        // Self in slot 0, tight limits, short remove count.
        write_reg(tms_pkg::REG_SELF, 17'd0);
        write_reg(tms_pkg::REG_PERIOD, 17'd131071);
        write_reg(tms_pkg::REG_LINK, 17'd0);
        write_reg(tms_pkg::REG_MINUPD, 17'd0);
        write_reg(tms_pkg::REG_REMOVE, 17'd1);
        send_event(OP_TICK, 3'd0, 24'd0);
        send_event(OP_RX, 3'd1, 24'd20000);
        send_event(OP_RX, 3'd2, 24'd50000);
        send_event(OP_TICK, 3'd0, 24'd0);
        send_event(OP_RX, 3'd1, 24'd30000);
        send_event(OP_TICK, 3'd0, 24'd0);
        drain();

        stall_enable = 1'b1;
        run_rounds(40);
        drain();

        // Extremes and random settings across phases; self out of range in phase 0.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(tms_pkg::REG_SELF, 17'd7);
                    write_reg(tms_pkg::REG_PERIOD, 17'd1);
                    write_reg(tms_pkg::REG_LINK, 17'd65535);
                    write_reg(tms_pkg::REG_MINUPD, 17'd65535);
                    write_reg(tms_pkg::REG_REMOVE, 17'd15);
                end
                1:
                begin
                    write_reg(tms_pkg::REG_SELF, 17'd4);
                    write_reg(tms_pkg::REG_PERIOD, 17'd75000);
                    write_reg(tms_pkg::REG_LINK, 17'd4000);
                    write_reg(tms_pkg::REG_MINUPD, 17'd1000);
                    write_reg(tms_pkg::REG_REMOVE, 17'd2);
                end
                default:
                begin
                    write_reg(tms_pkg::REG_SELF, 17'($urandom_range(0, 7)));
                    write_reg(tms_pkg::REG_PERIOD, 17'($urandom_range(1, 131071)));
                    write_reg(tms_pkg::REG_LINK, 17'($urandom_range(0, 65535)));
                    write_reg(tms_pkg::REG_MINUPD, 17'($urandom_range(0, 65535)));
                    write_reg(tms_pkg::REG_REMOVE, 17'($urandom_range(1, 15)));
                end
            endcase
            if (phase == 3) stall_enable = 1'b0;
            else stall_enable = 1'b1;
            run_rounds(20);
            drain();
        end

        $display("covered %0d ticks and %0d receptions, %0d results checked",
                 tick_total, rx_total, result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tms_pkg.sv
rtl/tms_ctrl.sv
rtl/tms_dp.sv
rtl/tdma_membership_slot_sync.sv
rtl/tms_checker.sv
sim/tdma_membership_slot_sync_checker.sv
sim/tdma_membership_slot_sync_tb.sv
